/* rtl/afc_pkg.sv */
package afc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int PLANE_COUNT    = 6;
    localparam int SIDE_PLANES    = 4;
    localparam int AXES           = 3;
    localparam int NORM_W         = 16;
    localparam int D_SHIFT        = 14;
    localparam int APB_DATA_W     = 64;
    localparam int APB_ADDR_W     = 6;
    localparam int REG_IDX_W      = 3;

    typedef struct packed {
        logic signed [NORM_W-1:0] d;
        logic signed [NORM_W-1:0] nz;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nx;
    } t_plane;

    typedef enum logic [1:0] {
        CLASS_OUTSIDE   = 2'd0,
        CLASS_INTERSECT = 2'd1,
        CLASS_INSIDE    = 2'd2
    } t_class;

    function automatic logic signed [NORM_W-1:0] norm_of(input t_plane pl, input int axis);
        logic signed [NORM_W-1:0] n;
        case (axis)
            0:       n = pl.nx;
            1:       n = pl.ny;
            default: n = pl.nz;
        endcase
        return n;
    endfunction

endpackage

/* rtl/afc_corner_sel.sv */
module afc_corner_sel #(
    parameter int COORD_BITS = afc_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [COORD_BITS-1:0] i_min [afc_pkg::AXES],
    input  logic signed [COORD_BITS-1:0] i_max [afc_pkg::AXES],
    input  logic                         i_skip,
    input  afc_pkg::t_plane              i_plane [afc_pkg::PLANE_COUNT],
    output logic signed [COORD_BITS-1:0] o_near [afc_pkg::PLANE_COUNT][afc_pkg::AXES],
    output logic signed [COORD_BITS-1:0] o_far  [afc_pkg::PLANE_COUNT][afc_pkg::AXES],
    output logic                         o_skip
);
    import afc_pkg::*;

    logic signed [COORD_BITS-1:0] r_near [PLANE_COUNT][AXES];
    logic signed [COORD_BITS-1:0] r_far  [PLANE_COUNT][AXES];
    logic                         r_skip;

    // zero normal counts as non-negative: min is the near coordinate
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_skip <= i_skip;
            for (int p = 0; p < PLANE_COUNT; p++) begin
                for (int a = 0; a < AXES; a++) begin
                    if (norm_of(i_plane[p], a) < 0) begin
                        r_near[p][a] <= i_max[a];
                        r_far[p][a]  <= i_min[a];
                    end else begin
                        r_near[p][a] <= i_min[a];
                        r_far[p][a]  <= i_max[a];
                    end
                end
            end
        end
    end

    assign o_near = r_near;
    assign o_far  = r_far;
    assign o_skip = r_skip;

endmodule

/* rtl/afc_dot.sv */
module afc_dot #(
    parameter int COORD_BITS = afc_pkg::COORD_BITS_DEF,
    parameter int SUM_W      = 32
) (
    input  logic                         i_clk,
    input  logic                         i_en_mul,
    input  logic                         i_en_sum,
    input  logic signed [COORD_BITS-1:0] i_near [afc_pkg::PLANE_COUNT][afc_pkg::AXES],
    input  logic signed [COORD_BITS-1:0] i_far  [afc_pkg::PLANE_COUNT][afc_pkg::AXES],
    input  logic                         i_skip,
    input  afc_pkg::t_plane              i_plane [afc_pkg::PLANE_COUNT],
    output logic signed [SUM_W-1:0]      o_lo [afc_pkg::PLANE_COUNT],
    output logic signed [SUM_W-1:0]      o_hi [afc_pkg::PLANE_COUNT],
    output logic                         o_skip
);
    import afc_pkg::*;

    localparam int PROD_W = NORM_W + COORD_BITS;

    logic signed [PROD_W-1:0] r_pn [PLANE_COUNT][AXES];
    logic signed [PROD_W-1:0] r_pf [PLANE_COUNT][AXES];
    logic                     r_skip_m;
    logic signed [SUM_W-1:0]  r_lo [PLANE_COUNT];
    logic signed [SUM_W-1:0]  r_hi [PLANE_COUNT];
    logic                     r_skip_s;
    logic signed [SUM_W-1:0]  n_lo [PLANE_COUNT];
    logic signed [SUM_W-1:0]  n_hi [PLANE_COUNT];

    // one multiplier per plane, axis and corner
    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_skip_m <= i_skip;
            for (int p = 0; p < PLANE_COUNT; p++) begin
                for (int a = 0; a < AXES; a++) begin
                    r_pn[p][a] <= PROD_W'(norm_of(i_plane[p], a) * i_near[p][a]);
                    r_pf[p][a] <= PROD_W'(norm_of(i_plane[p], a) * i_far[p][a]);
                end
            end
        end
    end

    always_comb begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            n_lo[p] = (SUM_W'(i_plane[p].d) <<< D_SHIFT)
                    + SUM_W'(r_pn[p][0]) + SUM_W'(r_pn[p][1]) + SUM_W'(r_pn[p][2]);
            n_hi[p] = (SUM_W'(i_plane[p].d) <<< D_SHIFT)
                    + SUM_W'(r_pf[p][0]) + SUM_W'(r_pf[p][1]) + SUM_W'(r_pf[p][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_skip_s <= r_skip_m;
            r_lo     <= n_lo;
            r_hi     <= n_hi;
        end
    end

    assign o_lo   = r_lo;
    assign o_hi   = r_hi;
    assign o_skip = r_skip_s;

endmodule

/* rtl/afc_classify.sv */
module afc_classify #(
    parameter int SUM_W = 32
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [SUM_W-1:0] i_lo [afc_pkg::PLANE_COUNT],
    input  logic signed [SUM_W-1:0] i_hi [afc_pkg::PLANE_COUNT],
    input  logic                    i_skip,
    output afc_pkg::t_class         o_class
);
    import afc_pkg::*;

    t_class r_class;
    t_class n_class;
    logic   w_out;
    logic   w_hit;

    // any outside plane wins, so plane order does not matter here
    always_comb begin
        w_out = 1'b0;
        w_hit = 1'b0;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            if (p < SIDE_PLANES || !i_skip) begin
                if (!i_lo[p][SUM_W-1] && (|i_lo[p])) w_out = 1'b1;
                if (!i_hi[p][SUM_W-1])               w_hit = 1'b1;
            end
        end
        if (w_out)      n_class = CLASS_OUTSIDE;
        else if (w_hit) n_class = CLASS_INTERSECT;
        else            n_class = CLASS_INSIDE;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_class <= n_class;
        end
    end

    assign o_class = r_class;

endmodule

/* rtl/aabb_frustum_cull.sv */
// throughput: one box per cycle while the output is not stalled, one multiplier per plane, axis and corner
// stages: corner select, multiply, plane sums, classify; bubbles close up under stall
// reset: synchronous active-low, clears the stage valid bits and all six planes to zero
// with all-zero planes every box comes out intersecting
module aabb_frustum_cull #(
    parameter int COORD_BITS = afc_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [COORD_BITS-1:0]        i_min_x,
    input  logic signed [COORD_BITS-1:0]        i_min_y,
    input  logic signed [COORD_BITS-1:0]        i_min_z,
    input  logic signed [COORD_BITS-1:0]        i_max_x,
    input  logic signed [COORD_BITS-1:0]        i_max_y,
    input  logic signed [COORD_BITS-1:0]        i_max_z,
    input  logic                                i_skip_near_far,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_cull_class,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [afc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [afc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [afc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import afc_pkg::*;

    localparam int PROD_W = NORM_W + COORD_BITS;
    localparam int D_W    = NORM_W + D_SHIFT;
    localparam int SUM_W  = ((PROD_W > D_W) ? PROD_W : D_W) + 2;
    localparam int STAGES = 4;

    t_plane                       r_plane [PLANE_COUNT];
    logic [STAGES-1:0]            r_v;
    logic [STAGES-1:0]            w_adv;
    logic [REG_IDX_W-1:0]         w_idx;
    logic signed [COORD_BITS-1:0] w_min [AXES];
    logic signed [COORD_BITS-1:0] w_max [AXES];
    logic signed [COORD_BITS-1:0] w_near [PLANE_COUNT][AXES];
    logic signed [COORD_BITS-1:0] w_far  [PLANE_COUNT][AXES];
    logic                         w_skip1;
    logic signed [SUM_W-1:0]      w_lo [PLANE_COUNT];
    logic signed [SUM_W-1:0]      w_hi [PLANE_COUNT];
    logic                         w_skip3;
    t_class                       w_class;

    // configuration port
    assign w_idx  = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                r_plane[p] <= '0;
            end
        end else if (psel && penable && pwrite && pready) begin
            if (int'(w_idx) < PLANE_COUNT) begin
                r_plane[w_idx] <= t_plane'(pwdata);
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (int'(w_idx) < PLANE_COUNT) begin
            prdata = APB_DATA_W'(r_plane[w_idx]);
        end
    end

    // a stage loads when it is empty or its contents move on
    always_comb begin
        w_adv[STAGES-1] = !r_v[STAGES-1] || i_ready;
        for (int k = STAGES-2; k >= 0; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) r_v[0] <= i_valid;
            for (int k = 1; k < STAGES; k++) begin
                if (w_adv[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_v[STAGES-1];

    assign w_min[0] = i_min_x;
    assign w_min[1] = i_min_y;
    assign w_min[2] = i_min_z;
    assign w_max[0] = i_max_x;
    assign w_max[1] = i_max_y;
    assign w_max[2] = i_max_z;

    afc_corner_sel #(
        .COORD_BITS (COORD_BITS)
    ) u_corner_sel (
        .i_clk   (i_clk),
        .i_en    (w_adv[0]),
        .i_min   (w_min),
        .i_max   (w_max),
        .i_skip  (i_skip_near_far),
        .i_plane (r_plane),
        .o_near  (w_near),
        .o_far   (w_far),
        .o_skip  (w_skip1)
    );

    afc_dot #(
        .COORD_BITS (COORD_BITS),
        .SUM_W      (SUM_W)
    ) u_dot (
        .i_clk    (i_clk),
        .i_en_mul (w_adv[1]),
        .i_en_sum (w_adv[2]),
        .i_near   (w_near),
        .i_far    (w_far),
        .i_skip   (w_skip1),
        .i_plane  (r_plane),
        .o_lo     (w_lo),
        .o_hi     (w_hi),
        .o_skip   (w_skip3)
    );

    afc_classify #(
        .SUM_W (SUM_W)
    ) u_classify (
        .i_clk   (i_clk),
        .i_en    (w_adv[3]),
        .i_lo    (w_lo),
        .i_hi    (w_hi),
        .i_skip  (w_skip3),
        .o_class (w_class)
    );

    assign o_cull_class = w_class;

endmodule

/* rtl/afc_checker.sv */
module afc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_cull_class
);
    import afc_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cull_class))
        else $error("result changed while stalled");

    a_class_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cull_class == CLASS_OUTSIDE || o_cull_class == CLASS_INTERSECT
                     || o_cull_class == CLASS_INSIDE))
        else $error("illegal cull class");

    // an empty output stage means the whole pipe can take an item
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output stage");

    // an accepted item reaches the output when the sink keeps taking
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready ##1 i_ready ##1 i_ready ##1 i_ready |=> o_valid)
        else $error("item did not reach output in four cycles");

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_cull_class (o_cull_class)
);
